[hdl/rc4_stream_cipher_assert.svh]
// assertion macros shared by the rc4 modules
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define RC4_ASSERT(lbl, clk_s, rst_n_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_n_s)) (prop)) \
		else $error("rc4 assertion failed");
// condition must never be seen outside reset
`define RC4_NEVER(lbl, clk_s, rst_n_s, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_n_s)) !(cond)) \
		else $error("rc4 forbidden condition");
`else
`define RC4_ASSERT(lbl, clk_s, rst_n_s, prop)
`define RC4_NEVER(lbl, clk_s, rst_n_s, cond)
`endif
`endif

[hdl/rc4_pkg.sv]
package rc4_pkg;

	localparam int BYTE_W            = 8;
	localparam int TABLE_SIZE        = 256;
	localparam int KEY_CNT_W         = 9;
	localparam int DEF_MAX_KEY_BYTES = 256;
	localparam int Q_DEPTH           = 4;

	// item kinds as sorted by the front end
	typedef enum logic [1:0] {
		OP_KEY_BYTE,
		OP_KEY_FINAL,
		OP_DATA,
		OP_DATA_FINAL
	} rc4_op_t;

	typedef struct packed {
		rc4_op_t           op;
		logic [BYTE_W-1:0] data;
	} rc4_item_t;

	// head of the queue as seen by the back end
	typedef struct packed {
		logic      valid;
		rc4_item_t item;
	} rc4_q_t;

endpackage

[hdl/rc4_stream_cipher.sv]
// rc4 engine: a keyed data beat runs through states DC_J, DC_WI, DC_WJ and DC_OUT into the
// output register; an unkeyed one goes there unchanged; the next beat is popped only in idle
// key beats are stored; the final one runs INIT, then KS_RD..KS_WJ, for each of 256 entries
// a 4-entry input queue keeps accepting beats while the engine is busy, until it is full
// arst_n clears indices, key count, keyed flag and queue; memories hold no reset value
module rc4_stream_cipher #(
	parameter int MAX_KEY_BYTES = rc4_pkg::DEF_MAX_KEY_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       mode,
	input  logic [7:0] data_byte,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       keyed
);
	import rc4_pkg::*;

	// queue head toward the engine and pop back
	rc4_q_t q_head;
	logic   q_pop;

	// front end: sorts beats into key / final key / data / final data and queues them
	rc4_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.data_byte (data_byte),
		.last      (last),
		.q_head    (q_head),
		.q_pop     (q_pop)
	);

	// back end: key store, schedule sequencer, keystream generator, output register
	rc4_core #(
		.MAX_KEY_BYTES (MAX_KEY_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.keyed     (keyed)
	);

endmodule

[hdl/rc4_front.sv]
`include "rc4_stream_cipher_assert.svh"

module rc4_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  mode,
	input  logic [7:0]            data_byte,
	input  logic                  last,
	output rc4_pkg::rc4_q_t       q_head,
	input  logic                  q_pop
);
	import rc4_pkg::*;

	localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	rc4_item_t            q_mem [Q_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	rc4_item_t            item_in;
	logic                 push;

	// sort the incoming beat
	always_comb begin
		item_in.data = data_byte;
		unique case ({mode, last})
			2'b00:   item_in.op = OP_KEY_BYTE;
			2'b01:   item_in.op = OP_KEY_FINAL;
			2'b10:   item_in.op = OP_DATA;
			default: item_in.op = OP_DATA_FINAL;
		endcase
	end

	assign in_stall    = (count_q == CNT_W'(Q_DEPTH));
	assign push        = in_valid && !in_stall;
	assign q_head.valid = (count_q != '0);
	assign q_head.item  = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !q_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (q_pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`RC4_ASSERT(a_cnt_bound, clk, arst_n, count_q <= CNT_W'(Q_DEPTH))
	`RC4_NEVER(a_pop_empty, clk, arst_n, q_pop && (count_q == '0))
	`RC4_ASSERT(a_cnt_grow, clk, arst_n, (push && !q_pop) |=> (count_q == $past(count_q) + CNT_W'(1)))

endmodule

[hdl/rc4_core.sv]
`include "rc4_stream_cipher_assert.svh"

module rc4_core #(
	parameter int MAX_KEY_BYTES = rc4_pkg::DEF_MAX_KEY_BYTES
) (
	input  logic            clk,
	input  logic            arst_n,
	input  rc4_pkg::rc4_q_t q_head,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      out_byte,
	output logic            keyed
);
	import rc4_pkg::*;

	localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_KS_RD,
		ST_KS_J,
		ST_KS_WN,
		ST_KS_WJ,
		ST_DC_J,
		ST_DC_WI,
		ST_DC_WJ,
		ST_DC_OUT
	} state_t;

	state_t                 state_q;
	logic [BYTE_W-1:0]      perm_mem [TABLE_SIZE];
	logic [BYTE_W-1:0]      key_mem  [MAX_KEY_BYTES];
	logic [BYTE_W-1:0]      perm_rdata_q;
	logic [BYTE_W-1:0]      key_rdata_q;
	logic [KEY_CNT_W-1:0]   key_cnt_q;
	logic [KEY_CNT_W-1:0]   len_q;
	logic [KW-1:0]          kidx_q;
	logic [BYTE_W-1:0]      n_q;
	logic [BYTE_W-1:0]      i_q;
	logic [BYTE_W-1:0]      j_q;
	logic [BYTE_W-1:0]      si_q;
	logic [BYTE_W-1:0]      sj_q;
	logic [BYTE_W-1:0]      byte_q;
	logic                   last_q;
	logic                   byp_q;
	logic                   key_ready_q;
	logic                   out_valid_q;
	logic [BYTE_W-1:0]      out_byte_q;
	logic                   out_keyed_q;

	logic                   perm_we;
	logic [BYTE_W-1:0]      perm_waddr;
	logic [BYTE_W-1:0]      perm_wdata;
	logic [BYTE_W-1:0]      perm_raddr;
	logic                   key_we;
	logic                   key_room;
	logic [KEY_CNT_W-1:0]   key_cnt_next;
	logic                   out_free;
	logic                   out_load;
	logic [BYTE_W-1:0]      out_byte_d;
	logic                   out_keyed_d;
	logic [BYTE_W-1:0]      ks_j;
	logic [BYTE_W-1:0]      dc_j;
	logic [BYTE_W-1:0]      t_idx;
	logic                   kidx_wrap;

	assign key_room     = (key_cnt_q < KEY_CNT_W'(MAX_KEY_BYTES));
	assign key_cnt_next = key_room ? key_cnt_q + KEY_CNT_W'(1) : key_cnt_q;
	assign out_free     = !out_valid_q || !out_stall;
	assign ks_j         = j_q + perm_rdata_q + key_rdata_q;
	assign dc_j         = j_q + perm_rdata_q;
	assign t_idx        = si_q + sj_q;
	assign kidx_wrap    = (KEY_CNT_W'(kidx_q) + KEY_CNT_W'(1) == len_q);

	// memory port control
	always_comb begin
		perm_we     = 1'b0;
		perm_waddr  = n_q;
		perm_wdata  = n_q;
		perm_raddr  = n_q;
		key_we      = 1'b0;
		q_pop       = 1'b0;
		out_load    = 1'b0;
		out_byte_d  = q_head.item.data;
		out_keyed_d = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_head.valid) begin
					unique case (q_head.item.op)
						OP_KEY_BYTE, OP_KEY_FINAL: begin
							q_pop  = 1'b1;
							key_we = key_room;
						end
						OP_DATA, OP_DATA_FINAL: begin
							if (key_ready_q) begin
								q_pop      = 1'b1;
								perm_raddr = i_q + BYTE_W'(1);
							end else if (out_free) begin
								q_pop    = 1'b1;
								out_load = 1'b1;
							end
						end
					endcase
				end
			end
			ST_INIT: begin
				perm_we = 1'b1;
			end
			ST_KS_RD: begin
				perm_raddr = n_q;
			end
			ST_KS_J: begin
				perm_raddr = ks_j;
			end
			ST_KS_WN: begin
				perm_we    = 1'b1;
				perm_wdata = perm_rdata_q;
			end
			ST_KS_WJ: begin
				perm_we    = 1'b1;
				perm_waddr = j_q;
				perm_wdata = si_q;
			end
			ST_DC_J: begin
				perm_raddr = dc_j;
			end
			ST_DC_WI: begin
				perm_we    = 1'b1;
				perm_waddr = i_q;
				perm_wdata = perm_rdata_q;
			end
			ST_DC_WJ: begin
				perm_we    = 1'b1;
				perm_waddr = j_q;
				perm_wdata = si_q;
				perm_raddr = t_idx;
			end
			ST_DC_OUT: begin
				// keep the keystream entry on the read port while the output waits
				perm_raddr = t_idx;
				if (out_free) begin
					out_load    = 1'b1;
					out_byte_d  = byte_q ^ (byp_q ? si_q : perm_rdata_q);
					out_keyed_d = 1'b1;
				end
			end
			default: begin
				perm_we = 1'b0;
			end
		endcase
	end

	// permutation and key memories, registered reads
	always_ff @(posedge clk) begin
		if (perm_we) begin
			perm_mem[perm_waddr] <= perm_wdata;
		end
		perm_rdata_q <= perm_mem[perm_raddr];
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_cnt_q[KW-1:0]] <= q_head.item.data;
		end
		key_rdata_q <= key_mem[kidx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_cnt_q   <= '0;
			len_q       <= '0;
			kidx_q      <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			si_q        <= '0;
			sj_q        <= '0;
			byte_q      <= '0;
			last_q      <= 1'b0;
			byp_q       <= 1'b0;
			key_ready_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_keyed_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= out_byte_d;
				out_keyed_q <= out_keyed_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						unique case (q_head.item.op)
							OP_KEY_BYTE: begin
								key_cnt_q <= key_cnt_next;
							end
							OP_KEY_FINAL: begin
								key_cnt_q <= key_cnt_next;
								len_q     <= key_cnt_next;
								n_q       <= '0;
								state_q   <= ST_INIT;
							end
							OP_DATA, OP_DATA_FINAL: begin
								byte_q <= q_head.item.data;
								last_q <= (q_head.item.op == OP_DATA_FINAL);
								if (key_ready_q) begin
									i_q     <= i_q + BYTE_W'(1);
									state_q <= ST_DC_J;
								end
							end
						endcase
					end
				end
				ST_INIT: begin
					n_q <= n_q + BYTE_W'(1);
					if (n_q == '1) begin
						j_q     <= '0;
						kidx_q  <= '0;
						state_q <= ST_KS_RD;
					end
				end
				ST_KS_RD: begin
					state_q <= ST_KS_J;
				end
				ST_KS_J: begin
					j_q     <= ks_j;
					si_q    <= perm_rdata_q;
					state_q <= ST_KS_WN;
				end
				ST_KS_WN: begin
					state_q <= ST_KS_WJ;
				end
				ST_KS_WJ: begin
					n_q    <= n_q + BYTE_W'(1);
					kidx_q <= kidx_wrap ? '0 : kidx_q + KW'(1);
					if (n_q == '1) begin
						key_ready_q <= 1'b1;
						key_cnt_q   <= '0;
						i_q         <= '0;
						j_q         <= '0;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_KS_RD;
					end
				end
				ST_DC_J: begin
					j_q     <= dc_j;
					si_q    <= perm_rdata_q;
					state_q <= ST_DC_WI;
				end
				ST_DC_WI: begin
					sj_q    <= perm_rdata_q;
					state_q <= ST_DC_WJ;
				end
				ST_DC_WJ: begin
					// keystream read collides with the swap write to j
					byp_q   <= (t_idx == j_q);
					state_q <= ST_DC_OUT;
				end
				ST_DC_OUT: begin
					if (out_free) begin
						if (last_q) begin
							i_q <= '0;
							j_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign keyed     = out_keyed_q;

	`RC4_ASSERT(a_sched_done, clk, arst_n, (state_q == ST_KS_WJ && n_q == '1) |=>
		(key_ready_q && key_cnt_q == '0 && i_q == '0 && j_q == '0))
	`RC4_ASSERT(a_cnt_bound, clk, arst_n, key_cnt_q <= KEY_CNT_W'(MAX_KEY_BYTES))
	`RC4_ASSERT(a_kidx_in_len, clk, arst_n, (state_q == ST_KS_RD) |->
		(len_q != '0 && KEY_CNT_W'(kidx_q) < len_q))
	`RC4_ASSERT(a_crypt_out, clk, arst_n, (state_q == ST_DC_OUT && out_free) |=>
		(out_valid_q && out_keyed_q && state_q == ST_IDLE))

endmodule
